// ----- design/psrr_pkg.sv -----
// Shared types and constants for the process slot round-robin scheduler.
`default_nettype none
package psrr_pkg;

  // Default number of process slots, slot 0 being the idle task.
  localparam int SLOTS_DEFAULT = 8;

  // Payload field widths.
  localparam int FUNC_W    = 2;
  localparam int PID_W     = 4;
  localparam int RPID_W    = 5;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Function codes of a request.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXIT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_YIELD = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PID = 2'd2;

  // Running id reported for the idle task.
  localparam logic [RPID_W-1:0] RPID_IDLE = 5'h1F;

  // Per-slot state codes.
  typedef enum logic [1:0] {
    SLOT_UNUSED = 2'd0,
    SLOT_READY  = 2'd1,
    SLOT_EXITED = 2'd2
  } slot_state_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ALLOC,
    SEQ_EXIT,
    SEQ_YIELD,
    SEQ_DONE
  } seq_state_t;

endpackage
`default_nettype wire

// ----- design/process_slot_round_robin_scheduler.sv -----
// Top level of the process slot round-robin scheduler with its scan sequencer.
//
// Requests enter on the s_tvalid/s_tready/s_tdata channel; each carries a
// function code (allocate, exit then yield, yield) and a target process id.
// Exactly one result leaves on m_tvalid/m_tready/m_tdata per request.
// A single slot-state read port and one compare unit are walked across the
// slot table, one slot per cycle, by a small sequencer:
//   allocate : accept, scan of up to SLOTS-1 slots, finish
//   exit     : accept, mark, scan of up to SLOTS slots, finish
//   yield    : accept, scan of up to SLOTS slots, finish
// An invalid exit id or an unknown code finishes right after the accept cycle.
// s_tready is high only while the sequencer waits for a request. The result
// sits in an output register, so a new request is taken while the previous
// result still waits; if the receiver stalls, the next finished result waits
// in the sequencer until the output register drains.
// Synchronous reset marks slot 0 (idle) ready, all others unused, makes the
// idle task the running one and empties the output register.
`default_nettype none
module process_slot_round_robin_scheduler #(
  parameter int SLOTS = psrr_pkg::SLOTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata: func [1:0], target_pid [5:2], zero [7:6]
  input  wire logic [psrr_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: status [1:0], new_pid [5:2], running_pid [10:6], switched [11],
  //          any_live [12], zero [15:13]
  output logic [psrr_pkg::OUT_DATA_W-1:0]      m_tdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS - 1);

  // Request fields.
  logic [psrr_pkg::FUNC_W-1:0] func;
  logic [psrr_pkg::PID_W-1:0]  target_pid;
  assign func       = s_tdata[1:0];
  assign target_pid = s_tdata[5:2];

  // Slot table and scheduler state.
  psrr_pkg::slot_state_t slot_state [SLOTS];
  logic [IDX_W-1:0] running_slot;
  logic [IDX_W-1:0] live_count;

  // Sequencer registers.
  psrr_pkg::seq_state_t state, state_next;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;

  // Result fields being built.
  logic [psrr_pkg::STATUS_W-1:0] status;
  logic [psrr_pkg::PID_W-1:0]    new_pid;
  logic                          switched;

  // Decoded control.
  logic accept;
  logic out_free;
  logic bad_pid;
  logic hit_ready;
  logic alloc_end;
  logic yield_end;
  psrr_pkg::slot_state_t cur;
  logic [IDX_W-1:0] target_idx;
  logic [IDX_W-1:0] yield_start;
  logic [IDX_W-1:0] idx_wrap;
  logic [IDX_W-1:0] pick;
  logic [psrr_pkg::RPID_W-1:0] running_pid;

  // Shared read port and compare unit on the slot table.
  assign cur       = slot_state[idx];
  assign hit_ready = (idx != '0) && (cur == psrr_pkg::SLOT_READY);
  assign alloc_end = (cur == psrr_pkg::SLOT_UNUSED) || (idx == LAST_IDX);
  assign yield_end = hit_ready || (cnt == LAST_CNT);
  assign pick      = hit_ready ? idx : '0;

  // Round-robin index arithmetic.
  assign idx_wrap    = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign yield_start = (running_slot == '0)       ? LAST_IDX :
                       (running_slot == LAST_IDX) ? '0 : running_slot + 1'b1;

  // Exit id checks: ids 0 and 1 and ids above the slot count are invalid.
  assign bad_pid    = (target_pid < 4'd2) || (32'(target_pid) > SLOTS);
  assign target_idx = IDX_W'(32'(target_pid) - 1);

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      psrr_pkg::SEQ_IDLE: begin
        if (accept) begin
          unique case (func)
            psrr_pkg::FUNC_ALLOC: state_next = psrr_pkg::SEQ_ALLOC;
            psrr_pkg::FUNC_EXIT:
              state_next = bad_pid ? psrr_pkg::SEQ_DONE : psrr_pkg::SEQ_EXIT;
            psrr_pkg::FUNC_YIELD: state_next = psrr_pkg::SEQ_YIELD;
            default:              state_next = psrr_pkg::SEQ_DONE;
          endcase
        end
      end
      psrr_pkg::SEQ_ALLOC: if (alloc_end) state_next = psrr_pkg::SEQ_DONE;
      psrr_pkg::SEQ_EXIT:  state_next = psrr_pkg::SEQ_YIELD;
      psrr_pkg::SEQ_YIELD: if (yield_end) state_next = psrr_pkg::SEQ_DONE;
      psrr_pkg::SEQ_DONE:  if (out_free) state_next = psrr_pkg::SEQ_IDLE;
      default:             state_next = psrr_pkg::SEQ_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    s_tready = (state == psrr_pkg::SEQ_IDLE);
  end

  // Reported running id: -1 for the idle task, slot index plus one otherwise.
  assign running_pid = (running_slot == '0) ? psrr_pkg::RPID_IDLE :
                       psrr_pkg::RPID_W'(32'(running_slot) + 1);

  // State register, slot table, running slot and live count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= psrr_pkg::SEQ_IDLE;
      running_slot <= '0;
      live_count   <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_state[s] <= (s == 0) ? psrr_pkg::SLOT_READY : psrr_pkg::SLOT_UNUSED;
      end
    end else begin
      state <= state_next;
      unique case (state)
        psrr_pkg::SEQ_ALLOC: begin
          if (cur == psrr_pkg::SLOT_UNUSED) begin
            slot_state[idx] <= psrr_pkg::SLOT_READY;
            live_count      <= live_count + 1'b1;
          end
        end
        psrr_pkg::SEQ_EXIT: begin
          if (cur == psrr_pkg::SLOT_READY) begin
            live_count <= live_count - 1'b1;
          end
          slot_state[idx] <= psrr_pkg::SLOT_EXITED;
        end
        psrr_pkg::SEQ_YIELD: begin
          if (yield_end) begin
            running_slot <= pick;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Scan index, step count and result fields under construction.
  always_ff @(posedge clk) begin
    unique case (state)
      psrr_pkg::SEQ_IDLE: begin
        status   <= (func == psrr_pkg::FUNC_EXIT && bad_pid) ?
                    psrr_pkg::STATUS_BAD_PID : psrr_pkg::STATUS_OK;
        new_pid  <= '0;
        switched <= 1'b0;
        cnt      <= '0;
        unique case (func)
          psrr_pkg::FUNC_ALLOC: idx <= IDX_W'(1);
          psrr_pkg::FUNC_EXIT:  idx <= target_idx;
          default:              idx <= yield_start;
        endcase
      end
      psrr_pkg::SEQ_ALLOC: begin
        if (cur == psrr_pkg::SLOT_UNUSED) begin
          new_pid <= psrr_pkg::PID_W'(32'(idx) + 1);
        end else if (idx == LAST_IDX) begin
          status <= psrr_pkg::STATUS_NO_SLOT;
        end
        idx <= idx_wrap;
      end
      psrr_pkg::SEQ_EXIT: begin
        idx <= yield_start;
        cnt <= '0;
      end
      psrr_pkg::SEQ_YIELD: begin
        if (yield_end) begin
          switched <= (pick != running_slot);
        end else begin
          idx <= idx_wrap;
          cnt <= cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: loads a finished result once the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == psrr_pkg::SEQ_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == psrr_pkg::SEQ_DONE && out_free) begin
      m_tdata <= {3'b000, (live_count != '0), switched, running_pid, new_pid, status};
    end
  end

endmodule
`default_nettype wire

// ----- design/psrr_checker.sv -----
// Port-level checker for the process slot round-robin scheduler, with its bind.
`default_nettype none
module psrr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [psrr_pkg::IN_DATA_W-1:0]  s_tdata,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [psrr_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A stalled result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Every request keeps the block busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted on consecutive cycles");

  // A nonzero new id only comes with an ok status and without a switch.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5:2] != 4'd0 |->
      m_tdata[1:0] == psrr_pkg::STATUS_OK && !m_tdata[11])
    else $error("new id reported with an error or a switch");

  // A rejected exit id neither allocates nor switches.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == psrr_pkg::STATUS_BAD_PID |->
      m_tdata[5:2] == 4'd0 && !m_tdata[11])
    else $error("invalid exit id changed state");

  // The running id is never zero: idle reads as -1, tasks as slot plus one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:6] != 5'd0)
    else $error("running id zero reported");

endmodule

bind process_slot_round_robin_scheduler psrr_checker u_psrr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- dv/tb_process_slot_round_robin_scheduler.sv -----
// Self-checking testbench for the process slot round-robin scheduler.
`timescale 1ns / 100ps
module tb_process_slot_round_robin_scheduler;
  import psrr_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int RAND_REQUESTS = 700;
  localparam int MAX_GAP = 13;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 30;
  // Code 3 is not a defined function; the block must treat it as a no-op.
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [PID_W-1:0]  pid;
  } sched_req_t;

  // Members run from the highest bit down, matching the m_tdata layout.
  typedef struct packed {
    logic                any_live;
    logic                switched;
    logic [RPID_W-1:0]   running_pid;
    logic [PID_W-1:0]    new_pid;
    logic [STATUS_W-1:0] status;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Stimulus and expected results.
  sched_req_t    pending_reqs[$];
  sched_result_t sched_expect[$];
  sched_req_t    cur_req;
  int            total_reqs = 0;
  int            accepted_cnt = 0;
  int            err_cnt = 0;
  int            cycle_cnt = 0;

  // Predictor state: the slot table and the running slot.
  slot_state_t   slot_tbl[SLOTS];
  int            run_slot;

  // Counters for the closing summary.
  int n_alloc_ok = 0, n_no_slot = 0, n_bad_pid = 0, n_switch = 0, n_nop = 0;

  // Idling controls for both sides.
  int  tx_gap = 0;
  int  rx_stall = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  process_slot_round_robin_scheduler #(.SLOTS(SLOTS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Round-robin pick of the next ready non-idle slot; returns 1 on a switch.
  function automatic logic pick_next_slot();
    int start;
    int pick;
    int s;
    start = (run_slot == 0) ? SLOTS - 1 : (run_slot + 1) % SLOTS;
    pick = 0;
    for (int i = 0; i < SLOTS; i++) begin
      s = (start + i) % SLOTS;
      if (pick == 0 && s != 0 && slot_tbl[s] == SLOT_READY) pick = s;
    end
    if (pick == run_slot) return 1'b0;
    run_slot = pick;
    return 1'b1;
  endfunction

  // Applies one request to the predictor state and returns its result.
  function automatic sched_result_t predict_sched(input sched_req_t req);
    sched_result_t r;
    logic found;
    r = '0;
    found = 1'b0;
    case (req.fn)
      FUNC_ALLOC: begin
        for (int s = 1; s < SLOTS; s++) begin
          if (!found && slot_tbl[s] == SLOT_UNUSED) begin
            slot_tbl[s] = SLOT_READY;
            r.new_pid = PID_W'(s + 1);
            found = 1'b1;
          end
        end
        if (!found) r.status = STATUS_NO_SLOT;
      end
      FUNC_EXIT: begin
        if (req.pid < 2 || int'(req.pid) > SLOTS) begin
          r.status = STATUS_BAD_PID;
        end else begin
          slot_tbl[int'(req.pid) - 1] = SLOT_EXITED;
          r.switched = pick_next_slot();
        end
      end
      FUNC_YIELD: begin
        r.switched = pick_next_slot();
      end
      default: ;
    endcase
    r.running_pid = (run_slot == 0) ? RPID_IDLE : RPID_W'(run_slot + 1);
    for (int s = 1; s < SLOTS; s++)
      if (slot_tbl[s] == SLOT_READY) r.any_live = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < MAX_PRINTED)
      $display("%0t ns: ERROR %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Request driver: presents queued requests with random gaps between them.
  always @(posedge clk) begin
    logic nxt_valid;
    sched_result_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        r = predict_sched(cur_req);
        sched_expect.push_back(r);
        accepted_cnt++;
        if (cur_req.fn == FUNC_ALLOC && r.status == STATUS_OK) n_alloc_ok++;
        if (r.status == STATUS_NO_SLOT) n_no_slot++;
        if (r.status == STATUS_BAD_PID) n_bad_pid++;
        if (cur_req.fn == FUNC_NOP) n_nop++;
        if (r.switched) n_switch++;
      end
      if (s_tvalid && !s_tready) begin
        nxt_valid = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
        nxt_valid = 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_tdata <= {2'b00, cur_req.pid, cur_req.fn};
        nxt_valid = 1'b1;
        if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        nxt_valid = 1'b0;
      end
      s_tvalid <= nxt_valid;
    end
  end

  // Result monitor: stalls at random and checks every accepted result.
  always @(posedge clk) begin
    sched_result_t want;
    sched_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = sched_result_t'(m_tdata[12:0]);
        if (sched_expect.size() == 0) begin
          report_mismatch("result with no request waiting", int'(m_tdata), -1);
        end else begin
          want = sched_expect.pop_front();
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.new_pid != want.new_pid)
            report_mismatch("new_pid", got.new_pid, want.new_pid);
          if (got.running_pid != want.running_pid)
            report_mismatch("running_pid", $signed(got.running_pid),
                            $signed(want.running_pid));
          if (got.switched != want.switched)
            report_mismatch("switched", got.switched, want.switched);
          if (got.any_live != want.any_live)
            report_mismatch("any_live", got.any_live, want.any_live);
        end
        if (m_tdata[15:13] != 3'b000)
          report_mismatch("m_tdata pad bits", m_tdata[15:13], 0);
        if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("process_slot_round_robin_scheduler: mismatch");
      $finish;
    end
  end

  initial begin
    int n;
    int pick;
    sched_req_t req;

    // Predictor reset: idle slot ready, all others unused.
    for (int s = 0; s < SLOTS; s++) slot_tbl[s] = SLOT_UNUSED;
    slot_tbl[0] = SLOT_READY;
    run_slot = 0;

    // Directed part: yield from idle, no-op code, invalid ids, allocation
    // up to exhaustion, exit of an unused, a ready and an exited slot.
    pending_reqs.push_back('{FUNC_YIELD, 4'd0});
    pending_reqs.push_back('{FUNC_NOP, 4'd15});
    pending_reqs.push_back('{FUNC_EXIT, 4'd0});
    pending_reqs.push_back('{FUNC_EXIT, 4'd1});
    pending_reqs.push_back('{FUNC_EXIT, 4'(SLOTS + 1)});
    pending_reqs.push_back('{FUNC_EXIT, 4'd15});
    pending_reqs.push_back('{FUNC_ALLOC, 4'd15});
    pending_reqs.push_back('{FUNC_YIELD, 4'd15});
    pending_reqs.push_back('{FUNC_YIELD, 4'd0});
    pending_reqs.push_back('{FUNC_EXIT, 4'(SLOTS)});
    for (int i = 0; i < SLOTS - 2; i++) pending_reqs.push_back('{FUNC_ALLOC, 4'd0});
    pending_reqs.push_back('{FUNC_YIELD, 4'd0});
    pending_reqs.push_back('{FUNC_YIELD, 4'd0});
    pending_reqs.push_back('{FUNC_EXIT, 4'(SLOTS)});
    pending_reqs.push_back('{FUNC_EXIT, 4'd3});
    pending_reqs.push_back('{FUNC_YIELD, 4'd0});
    pending_reqs.push_back('{FUNC_EXIT, 4'd2});
    pending_reqs.push_back('{FUNC_YIELD, 4'd0});

    // Random part: mostly yields, some allocations, bad exits and unknown codes, and rare
    // valid exits so that live processes stay around for a long stretch.
    n = 0;
    while (n < RAND_REQUESTS) begin
      pick = $urandom_range(0, 99);
      req.pid = 4'($urandom_range(0, 15));
      if (pick < 3) begin
        req.fn = FUNC_EXIT;
        req.pid = 4'($urandom_range(2, SLOTS));
      end else if (pick < 20) begin
        req.fn = FUNC_ALLOC;
      end else if (pick < 35) begin
        req.fn = FUNC_EXIT;
        req.pid = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 1))
                                              : 4'($urandom_range(SLOTS + 1, 15));
      end else if (pick < 42) begin
        req.fn = FUNC_NOP;
      end else begin
        req.fn = FUNC_YIELD;
      end
      pending_reqs.push_back(req);
      n++;
    end
    total_reqs = pending_reqs.size();

    // Reset once, then let the driver and the monitor run.
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_reqs || sched_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d allocations, %0d without a free slot, %0d bad ids,",
             accepted_cnt, n_alloc_ok, n_no_slot, n_bad_pid);
    $display("%0d task switches and %0d unknown codes, with %0d errors.",
             n_switch, n_nop, err_cnt);
    if (err_cnt == 0) begin
      $display("process_slot_round_robin_scheduler: match");
    end else begin
      $display("process_slot_round_robin_scheduler: mismatch");
    end
    $finish;
  end

endmodule
